// File: hw/rtl/bpei_pkg.sv
// Package for the breakpoint envelope interpolator.
// Holds table sizes, item kinds, status codes, cell control types and FSM states.
// No dependencies.
package bpei_pkg;

    localparam int MAX_POINTS = 64;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int TIME_W     = 32;
    localparam int LVL_W      = 17;
    localparam int VAL_W      = 18;
    localparam int FRAC_W     = 17;
    localparam int PROD_W     = FRAC_W + LVL_W;
    localparam int DSTEP_W    = $clog2(FRAC_W);

    localparam logic [LVL_W-1:0] LEVEL_ONE  = LVL_W'(65536);
    localparam logic [LVL_W-1:0] LEVEL_HALF = LVL_W'(32768);

    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_CLEAR  = 2'd2,
        KIND_QUERY  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        STAT_DONE     = 2'd0,
        STAT_FULL     = 2'd1,
        STAT_BAD_IDX  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE,
        CELL_LOAD,
        CELL_SHIFT
    } t_cell_op;

    typedef struct packed {
        t_cell_op            op;
        logic [TIME_W-1:0]   t;
        logic [LVL_W-1:0]    lvl;
        logic [CNT_W-1:0]    count;
        logic [IDX_W-1:0]    rm_idx;
    } t_cell_ctl;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DIV,
        ST_MUL,
        ST_FIN,
        ST_DONE
    } t_state;

endpackage

// File: hw/rtl/bpei_cell.sv
// One breakpoint cell: a stored point plus a scan register that shifts toward cell 0.
// Depends on bpei_pkg.
module bpei_cell (
    input  logic                           i_clk,
    input  bpei_pkg::t_cell_ctl            i_ctl,
    input  logic [bpei_pkg::IDX_W-1:0]     i_idx,
    input  logic                           i_left_lt,
    input  logic [bpei_pkg::TIME_W-1:0]    i_left_time,
    input  logic [bpei_pkg::LVL_W-1:0]     i_left_lvl,
    input  logic [bpei_pkg::TIME_W-1:0]    i_right_time,
    input  logic [bpei_pkg::LVL_W-1:0]     i_right_lvl,
    input  logic [bpei_pkg::TIME_W-1:0]    i_right_pass_time,
    input  logic [bpei_pkg::LVL_W-1:0]     i_right_pass_lvl,
    output logic                           o_lt,
    output logic [bpei_pkg::TIME_W-1:0]    o_time,
    output logic [bpei_pkg::LVL_W-1:0]     o_lvl,
    output logic [bpei_pkg::TIME_W-1:0]    o_pass_time,
    output logic [bpei_pkg::LVL_W-1:0]     o_pass_lvl
);

    logic [bpei_pkg::TIME_W-1:0] r_time, n_time, r_pass_time, n_pass_time;
    logic [bpei_pkg::LVL_W-1:0]  r_lvl, n_lvl, r_pass_lvl, n_pass_lvl;
    logic                        valid;

    assign valid = {1'b0, i_idx} < i_ctl.count;
    assign o_lt  = valid && (r_time < i_ctl.t);

    always_comb begin
        n_time      = r_time;
        n_lvl       = r_lvl;
        n_pass_time = r_pass_time;
        n_pass_lvl  = r_pass_lvl;
        case (i_ctl.op)
            bpei_pkg::CELL_INSERT: begin
                // points below the new time stay, the first one at or above takes the
                // new point, the rest move one place up
                if (!o_lt) begin
                    if (i_left_lt) begin
                        n_time = i_ctl.t;
                        n_lvl  = i_ctl.lvl;
                    end else begin
                        n_time = i_left_time;
                        n_lvl  = i_left_lvl;
                    end
                end
            end
            bpei_pkg::CELL_REMOVE: begin
                if (i_idx >= i_ctl.rm_idx) begin
                    n_time = i_right_time;
                    n_lvl  = i_right_lvl;
                end
            end
            bpei_pkg::CELL_LOAD: begin
                n_pass_time = r_time;
                n_pass_lvl  = r_lvl;
            end
            bpei_pkg::CELL_SHIFT: begin
                n_pass_time = i_right_pass_time;
                n_pass_lvl  = i_right_pass_lvl;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_time      <= n_time;
        r_lvl       <= n_lvl;
        r_pass_time <= n_pass_time;
        r_pass_lvl  <= n_pass_lvl;
    end

    assign o_time      = r_time;
    assign o_lvl       = r_lvl;
    assign o_pass_time = r_pass_time;
    assign o_pass_lvl  = r_pass_lvl;

endmodule

// File: hw/rtl/breakpoint_envelope_interpolator_top.sv
// Flow: insert, remove and clear go straight to ST_DONE; a query walks ST_SCAN over the stored
// points, then ST_DIV (bit-serial divide), ST_MUL and ST_FIN unless it resolves in the scan.
// Throughput: one request at a time; set by the cell-chain scan and the bit-serial divider.
// Reset (i_rst_n low, synchronous) empties the table and drops any pending result.
// Depends on bpei_pkg and bpei_cell.
module breakpoint_envelope_interpolator_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [55:0] i_s_tdata,   // point_time[31:0], point_value[49:32], point_index[55:50]
    input  logic [1:0]  i_s_tuser,   // kind[1:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata    // level[16:0], point_count[23:17], status[25:24], zeros
);

    localparam int N  = bpei_pkg::MAX_POINTS;
    localparam int TW = bpei_pkg::TIME_W;
    localparam int LW = bpei_pkg::LVL_W;
    localparam int CW = bpei_pkg::CNT_W;

    // request fields
    logic [TW-1:0]                 in_time;
    logic signed [bpei_pkg::VAL_W-1:0] in_val;
    logic [bpei_pkg::IDX_W-1:0]    in_idx;
    bpei_pkg::t_kind               in_kind;
    logic [LW-1:0]                 in_lvl;
    logic                          accept;

    assign in_time = i_s_tdata[31:0];
    assign in_val  = i_s_tdata[49:32];
    assign in_idx  = i_s_tdata[55:50];
    assign in_kind = bpei_pkg::t_kind'(i_s_tuser);

    // clamp the inserted level to 0..1.0
    always_comb begin
        if (in_val < 0)
            in_lvl = '0;
        else if (in_val > $signed({1'b0, bpei_pkg::LEVEL_ONE}))
            in_lvl = bpei_pkg::LEVEL_ONE;
        else
            in_lvl = in_val[LW-1:0];
    end

    // control state
    bpei_pkg::t_state        r_state, n_state;
    logic [CW-1:0]           r_count, n_count;
    logic [TW-1:0]           r_qt, n_qt;           // query time
    logic [CW-1:0]           r_k, n_k;             // scan position
    logic                    r_found, n_found;
    logic                    r_direct, n_direct;
    logic [TW-1:0]           r_t0, n_t0, r_prev_t, n_prev_t, r_seg, n_seg;
    logic [LW-1:0]           r_v0, n_v0, r_v1, n_v1, r_prev_v, n_prev_v;
    logic [TW:0]             r_rem, n_rem;
    logic [bpei_pkg::FRAC_W-1:0] r_q, n_q;
    logic [bpei_pkg::DSTEP_W-1:0] r_dcnt, n_dcnt;
    logic [bpei_pkg::PROD_W-1:0]  r_prod, n_prod;
    logic                    r_up, n_up;
    logic [LW-1:0]           r_res_lvl, n_res_lvl;
    bpei_pkg::t_status       r_res_stat, n_res_stat;
    logic                    r_out_valid, n_out_valid;
    logic [LW-1:0]           r_out_lvl, n_out_lvl;
    logic [CW-1:0]           r_out_cnt, n_out_cnt;
    bpei_pkg::t_status       r_out_stat, n_out_stat;

    bpei_pkg::t_cell_ctl     cell_ctl;

    // cell chain wiring
    logic          c_lt        [N];
    logic [TW-1:0] c_time      [N];
    logic [LW-1:0] c_lvl       [N];
    logic [TW-1:0] c_pass_time [N];
    logic [LW-1:0] c_pass_lvl  [N];

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_cell
            logic          left_lt;
            logic [TW-1:0] left_time, right_time, right_pass_time;
            logic [LW-1:0] left_lvl, right_lvl, right_pass_lvl;
            if (g == 0) begin : g_first
                // nothing sits left of cell 0, so it behaves as if its neighbor is lower
                assign left_lt   = 1'b1;
                assign left_time = '0;
                assign left_lvl  = '0;
            end else begin : g_mid
                assign left_lt   = c_lt[g-1];
                assign left_time = c_time[g-1];
                assign left_lvl  = c_lvl[g-1];
            end
            if (g == N - 1) begin : g_last
                assign right_time      = '0;
                assign right_lvl       = '0;
                assign right_pass_time = '0;
                assign right_pass_lvl  = '0;
            end else begin : g_inner
                assign right_time      = c_time[g+1];
                assign right_lvl       = c_lvl[g+1];
                assign right_pass_time = c_pass_time[g+1];
                assign right_pass_lvl  = c_pass_lvl[g+1];
            end
            bpei_cell u_cell (
                .i_clk             (i_clk),
                .i_ctl             (cell_ctl),
                .i_idx             (bpei_pkg::IDX_W'(g)),
                .i_left_lt         (left_lt),
                .i_left_time       (left_time),
                .i_left_lvl        (left_lvl),
                .i_right_time      (right_time),
                .i_right_lvl       (right_lvl),
                .i_right_pass_time (right_pass_time),
                .i_right_pass_lvl  (right_pass_lvl),
                .o_lt              (c_lt[g]),
                .o_time            (c_time[g]),
                .o_lvl             (c_lvl[g]),
                .o_pass_time       (c_pass_time[g]),
                .o_pass_lvl        (c_pass_lvl[g])
            );
        end
    endgenerate

    // head of the scan chain: entry r_k during ST_SCAN
    logic [TW-1:0] head_t;
    logic [LW-1:0] head_v;
    assign head_t = c_pass_time[0];
    assign head_v = c_pass_lvl[0];

    // divider step and final add
    logic [TW:0]   trial;
    logic          qbit;
    logic [bpei_pkg::PROD_W:0] down_sum;

    assign trial    = (r_dcnt == '0) ? r_rem : {r_rem[TW-1:0], 1'b0};
    assign qbit     = trial >= {1'b0, r_seg};
    assign down_sum = {1'b0, r_prod} + (bpei_pkg::PROD_W + 1)'(65535);

    assign accept = i_s_tvalid && o_s_tready;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_qt        = r_qt;
        n_k         = r_k;
        n_found     = r_found;
        n_direct    = r_direct;
        n_t0        = r_t0;
        n_prev_t    = r_prev_t;
        n_prev_v    = r_prev_v;
        n_seg       = r_seg;
        n_v0        = r_v0;
        n_v1        = r_v1;
        n_rem       = r_rem;
        n_q         = r_q;
        n_dcnt      = r_dcnt;
        n_prod      = r_prod;
        n_up        = r_up;
        n_res_lvl   = r_res_lvl;
        n_res_stat  = r_res_stat;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_lvl   = r_out_lvl;
        n_out_cnt   = r_out_cnt;
        n_out_stat  = r_out_stat;

        cell_ctl.op     = bpei_pkg::CELL_HOLD;
        cell_ctl.t      = in_time;
        cell_ctl.lvl    = in_lvl;
        cell_ctl.count  = r_count;
        cell_ctl.rm_idx = in_idx;
        o_s_tready      = 1'b0;

        unique case (r_state)
            bpei_pkg::ST_IDLE: begin
                o_s_tready = 1'b1;
                if (accept) begin
                    n_res_lvl  = '0;
                    n_res_stat = bpei_pkg::STAT_DONE;
                    n_state    = bpei_pkg::ST_DONE;
                    unique case (in_kind)
                        bpei_pkg::KIND_INSERT: begin
                            if (r_count == CW'(N)) begin
                                n_res_stat = bpei_pkg::STAT_FULL;
                            end else begin
                                cell_ctl.op = bpei_pkg::CELL_INSERT;
                                n_count     = r_count + 1'b1;
                            end
                        end
                        bpei_pkg::KIND_REMOVE: begin
                            if ({1'b0, in_idx} >= r_count) begin
                                n_res_stat = bpei_pkg::STAT_BAD_IDX;
                            end else begin
                                cell_ctl.op = bpei_pkg::CELL_REMOVE;
                                n_count     = r_count - 1'b1;
                            end
                        end
                        bpei_pkg::KIND_CLEAR: begin
                            n_count = '0;
                        end
                        bpei_pkg::KIND_QUERY: begin
                            if (r_count == '0) begin
                                n_res_lvl = bpei_pkg::LEVEL_HALF;
                            end else begin
                                cell_ctl.op = bpei_pkg::CELL_LOAD;
                                n_qt     = in_time;
                                n_k      = '0;
                                n_found  = 1'b0;
                                n_direct = 1'b0;
                                n_state  = bpei_pkg::ST_SCAN;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            bpei_pkg::ST_SCAN: begin
                cell_ctl.op = bpei_pkg::CELL_SHIFT;
                n_prev_t    = head_t;
                n_prev_v    = head_v;
                n_k         = r_k + 1'b1;
                // first entry at or above the query time closes the segment
                if (!r_found && head_t >= r_qt) begin
                    n_found = 1'b1;
                    if (r_k == '0) begin
                        n_direct  = 1'b1;
                        n_res_lvl = head_v;
                    end else begin
                        n_t0  = r_prev_t;
                        n_v0  = r_prev_v;
                        n_v1  = head_v;
                        n_seg = head_t - r_prev_t;
                    end
                end
                if (r_k == r_count - 1'b1) begin
                    // at or past the last point the last level holds, unless the
                    // query already sits at or before the first point
                    if (r_direct || (r_k == '0 && head_t >= r_qt)) begin
                        n_state = bpei_pkg::ST_DONE;
                    end else if (head_t <= r_qt) begin
                        n_res_lvl = head_v;
                        n_state   = bpei_pkg::ST_DONE;
                    end else begin
                        n_state = bpei_pkg::ST_DIV;
                        n_dcnt  = '0;
                        n_q     = '0;
                    end
                    n_rem = {1'b0, r_qt - ((!r_found && r_k != '0 && head_t >= r_qt)
                                           ? r_prev_t : r_t0)};
                end
            end
            bpei_pkg::ST_DIV: begin
                if (r_seg == '0) begin
                    // zero-length segment answers its start level
                    n_res_lvl = r_v0;
                    n_state   = bpei_pkg::ST_DONE;
                end else begin
                    n_rem  = qbit ? (trial - {1'b0, r_seg}) : trial;
                    n_q    = {r_q[bpei_pkg::FRAC_W-2:0], qbit};
                    n_dcnt = r_dcnt + 1'b1;
                    if (r_dcnt == bpei_pkg::DSTEP_W'(bpei_pkg::FRAC_W - 1))
                        n_state = bpei_pkg::ST_MUL;
                end
            end
            bpei_pkg::ST_MUL: begin
                n_up    = r_v1 >= r_v0;
                n_prod  = r_q * (r_v1 >= r_v0 ? (r_v1 - r_v0) : (r_v0 - r_v1));
                n_state = bpei_pkg::ST_FIN;
            end
            bpei_pkg::ST_FIN: begin
                // down slopes round the step magnitude up, matching an arithmetic shift
                if (r_up)
                    n_res_lvl = r_v0 + LW'(r_prod[bpei_pkg::PROD_W-1:16]);
                else
                    n_res_lvl = r_v0 - LW'(down_sum[bpei_pkg::PROD_W-1:16]);
                n_state = bpei_pkg::ST_DONE;
            end
            bpei_pkg::ST_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_lvl   = r_res_lvl;
                    n_out_cnt   = r_count;
                    n_out_stat  = r_res_stat;
                    n_state     = bpei_pkg::ST_IDLE;
                end
            end
            default: n_state = bpei_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bpei_pkg::ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_dcnt      <= '0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_dcnt      <= n_dcnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_qt       <= n_qt;
        r_k        <= n_k;
        r_found    <= n_found;
        r_direct   <= n_direct;
        r_t0       <= n_t0;
        r_prev_t   <= n_prev_t;
        r_prev_v   <= n_prev_v;
        r_seg      <= n_seg;
        r_v0       <= n_v0;
        r_v1       <= n_v1;
        r_rem      <= n_rem;
        r_q        <= n_q;
        r_prod     <= n_prod;
        r_up       <= n_up;
        r_res_lvl  <= n_res_lvl;
        r_res_stat <= n_res_stat;
        r_out_lvl  <= n_out_lvl;
        r_out_cnt  <= n_out_cnt;
        r_out_stat <= n_out_stat;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'd0, r_out_stat, r_out_cnt, r_out_lvl};

`ifndef ASSERT_OFF
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(N))
        else $error("point count above capacity");

    a_busy_no_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != bpei_pkg::ST_IDLE) |-> !o_s_tready)
        else $error("request taken while busy");

    a_div_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bpei_pkg::ST_DIV) |-> (r_dcnt < bpei_pkg::DSTEP_W'(bpei_pkg::FRAC_W)))
        else $error("divider ran past its step count");
`endif

endmodule

// File: tb/tb_breakpoint_envelope_interpolator_top.sv
// Self-checking testbench for breakpoint_envelope_interpolator_top.
// Runs a directed table, then random requests, and checks every result against its typed
// answer or a predictor of the sorted breakpoint table; depends on bpei_pkg and the RTL only.
module tb_breakpoint_envelope_interpolator_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 4000;   // idle cycles allowed with no handshake
    localparam int RANDOM_ITEMS   = 1600;
    localparam int LONG_HOLD      = 600;    // receiver back-pressure stretch
    localparam int DRAIN_CYCLES   = 120;    // covers the longest query latency

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [55:0] i_s_tdata;   // point_time[31:0], point_value[49:32], point_index[55:50]
    logic [1:0]  i_s_tuser;   // kind[1:0]
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [31:0] o_m_tdata;   // level[16:0], point_count[23:17], status[25:24], zeros

    breakpoint_envelope_interpolator_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // One answer from the block.
    typedef struct {
        logic [bpei_pkg::LVL_W-1:0] level;
        logic [bpei_pkg::CNT_W-1:0] count;
        bpei_pkg::t_status          status;
    } t_answer;

    // One row of the directed table; chk says whether the answer is typed in.
    typedef struct {
        bpei_pkg::t_kind    kind;
        logic [31:0]        t;
        logic signed [17:0] val;
        logic [5:0]         idx;
        bit                 chk;
        t_answer            ans;
    } t_row;

    // Predictor copy of the breakpoint table.
    logic [31:0]                env_times  [bpei_pkg::MAX_POINTS];
    logic [bpei_pkg::LVL_W-1:0] env_levels [bpei_pkg::MAX_POINTS];
    int                         env_count;

    t_answer answers_due[$];
    bit      failed;
    bit      sending_done;
    int      idle_cycles;
    int      answers_seen;

    // Linear interpolation inside segment i, as the block does it in fixed point.
    function automatic logic [bpei_pkg::LVL_W-1:0] seg_level(logic [31:0] t, int i);
        longint unsigned seg, frac, mag, v0, v1;
        v0  = env_levels[i];
        v1  = env_levels[i+1];
        seg = env_times[i+1] - env_times[i];
        if (seg == 0) return v0[bpei_pkg::LVL_W-1:0];
        frac = ((t - env_times[i]) << 16) / seg;
        if (v1 >= v0) begin
            mag = frac * (v1 - v0);
            return bpei_pkg::LVL_W'(v0 + (mag >> 16));
        end
        mag = frac * (v0 - v1);
        return bpei_pkg::LVL_W'(v0 - ((mag + 65535) >> 16));   // floor of a negative step
    endfunction

    function automatic logic [bpei_pkg::LVL_W-1:0] level_at(logic [31:0] t);
        if (env_count == 0) return bpei_pkg::LEVEL_HALF;
        if (t <= env_times[0]) return env_levels[0];
        if (t >= env_times[env_count-1]) return env_levels[env_count-1];
        for (int i = 0; i + 1 < env_count; i++)
            if (t >= env_times[i] && t <= env_times[i+1]) return seg_level(t, i);
        return bpei_pkg::LEVEL_HALF;
    endfunction

    // Applies one request to the table copy and returns the answer it should give.
    function automatic t_answer envelope_update(bpei_pkg::t_kind kind, logic [31:0] t,
                                                logic signed [17:0] val, logic [5:0] idx);
        t_answer a;
        int pos;
        a.level  = '0;
        a.status = bpei_pkg::STAT_DONE;
        case (kind)
            bpei_pkg::KIND_INSERT: begin
                if (env_count >= bpei_pkg::MAX_POINTS) begin
                    a.status = bpei_pkg::STAT_FULL;
                end else begin
                    pos = 0;
                    while (pos < env_count && env_times[pos] < t) pos++;
                    for (int j = env_count; j > pos; j--) begin
                        env_times[j]  = env_times[j-1];
                        env_levels[j] = env_levels[j-1];
                    end
                    env_times[pos]  = t;
                    env_levels[pos] = (val < 0) ? '0 :
                                      (val > 65536) ? bpei_pkg::LEVEL_ONE :
                                      bpei_pkg::LVL_W'(val);
                    env_count++;
                end
            end
            bpei_pkg::KIND_REMOVE: begin
                if (idx >= env_count) begin
                    a.status = bpei_pkg::STAT_BAD_IDX;
                end else begin
                    for (int j = idx; j + 1 < env_count; j++) begin
                        env_times[j]  = env_times[j+1];
                        env_levels[j] = env_levels[j+1];
                    end
                    env_count--;
                end
            end
            bpei_pkg::KIND_CLEAR: env_count = 0;
            default:              a.level = level_at(t);
        endcase
        a.count = bpei_pkg::CNT_W'(env_count);
        return a;
    endfunction

    // Offers one request after a random gap and waits for the handshake.
    task automatic offer_request(bpei_pkg::t_kind kind, logic [31:0] t,
                                 logic signed [17:0] val, logic [5:0] idx, bit chk,
                                 t_answer typed);
        int gap;
        t_answer a;
        gap = ($urandom_range(0, 9) < 6) ? 0 :
              ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(10, 40);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {idx, val, t};
        i_s_tuser  <= kind;
        do @(posedge i_clk); while (!o_s_tready);
        a = envelope_update(kind, t, val, idx);
        answers_due.push_back(chk ? typed : a);
    endtask

    function automatic logic [31:0] pick_time();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)  return 32'h0;
        if (r < 6)  return 32'hFFFF_FFFF;
        if (r < 16) return $urandom;
        if (r < 30 && env_count > 0) return env_times[$urandom_range(0, env_count-1)];
        return $urandom_range(0, 2000);
    endfunction

    function automatic logic signed [17:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)  return 18'sh1FFFF;
        if (r < 10) return -18'sh20000;
        if (r < 30) return 18'($urandom);
        return 18'($urandom_range(0, 65536));
    endfunction

    // Sender: reset, directed table, then random requests.
    initial begin
        t_row rows[$];
        t_answer none;
        int ins_w, rem_w, r;
        bpei_pkg::t_kind k;
        logic [5:0] idx;
        none = '{level: '0, count: '0, status: bpei_pkg::STAT_DONE};
        i_rst_n      = 1'b0;
        i_s_tvalid   = 1'b0;
        i_s_tdata    = '0;
        i_s_tuser    = '0;
        sending_done = 1'b0;
        env_count    = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty table, bad indexes, clamping, holds at both ends, midpoint
        rows = '{
            '{bpei_pkg::KIND_QUERY,  32'h0,        18'sd0,       6'd0,  1,
              '{bpei_pkg::LEVEL_HALF, 7'd0, bpei_pkg::STAT_DONE}},
            '{bpei_pkg::KIND_QUERY,  32'hFFFFFFFF, 18'sd0,       6'd0,  1,
              '{bpei_pkg::LEVEL_HALF, 7'd0, bpei_pkg::STAT_DONE}},
            '{bpei_pkg::KIND_REMOVE, 32'h0,        18'sd0,       6'd0,  1,
              '{17'd0, 7'd0, bpei_pkg::STAT_BAD_IDX}},
            '{bpei_pkg::KIND_REMOVE, 32'h0,        18'sd0,       6'd63, 1,
              '{17'd0, 7'd0, bpei_pkg::STAT_BAD_IDX}},
            '{bpei_pkg::KIND_INSERT, 32'd100,      -18'sd131072, 6'd0,  1,
              '{17'd0, 7'd1, bpei_pkg::STAT_DONE}},
            '{bpei_pkg::KIND_INSERT, 32'd300,      18'sd131071,  6'd0,  1,
              '{17'd0, 7'd2, bpei_pkg::STAT_DONE}},
            '{bpei_pkg::KIND_QUERY,  32'h0,        18'sd0,       6'd0,  1,
              '{17'd0, 7'd2, bpei_pkg::STAT_DONE}},
            '{bpei_pkg::KIND_QUERY,  32'hFFFFFFFF, 18'sd0,       6'd0,  1,
              '{bpei_pkg::LEVEL_ONE, 7'd2, bpei_pkg::STAT_DONE}},
            '{bpei_pkg::KIND_QUERY,  32'd200,      18'sd0,       6'd0,  1,
              '{bpei_pkg::LEVEL_HALF, 7'd2, bpei_pkg::STAT_DONE}},
            '{bpei_pkg::KIND_INSERT, 32'd300,      18'sd70000,   6'd0,  0, none},
            '{bpei_pkg::KIND_INSERT, 32'd300,      18'sd0,       6'd0,  0, none},
            '{bpei_pkg::KIND_QUERY,  32'd300,      18'sd0,       6'd0,  0, none},
            '{bpei_pkg::KIND_QUERY,  32'd250,      18'sd0,       6'd0,  0, none},
            '{bpei_pkg::KIND_INSERT, 32'd200,      18'sd40000,   6'd0,  0, none},
            '{bpei_pkg::KIND_QUERY,  32'd150,      18'sd0,       6'd0,  0, none},
            '{bpei_pkg::KIND_QUERY,  32'd257,      18'sd0,       6'd0,  0, none},
            '{bpei_pkg::KIND_REMOVE, 32'h0,        18'sd0,       6'd1,  0, none},
            '{bpei_pkg::KIND_INSERT, 32'h0,        18'sd65536,   6'd0,  0, none},
            '{bpei_pkg::KIND_INSERT, 32'hFFFFFFFF, 18'sd1,       6'd0,  0, none},
            '{bpei_pkg::KIND_QUERY,  32'h80000000, 18'sd0,       6'd0,  0, none},
            '{bpei_pkg::KIND_QUERY,  32'd99,       18'sd0,       6'd0,  0, none},
            '{bpei_pkg::KIND_CLEAR,  32'h0,        18'sd0,       6'd0,  1,
              '{17'd0, 7'd0, bpei_pkg::STAT_DONE}},
            '{bpei_pkg::KIND_QUERY,  32'd5,        18'sd0,       6'd0,  1,
              '{bpei_pkg::LEVEL_HALF, 7'd0, bpei_pkg::STAT_DONE}}
        };
        foreach (rows[i])
            offer_request(rows[i].kind, rows[i].t, rows[i].val, rows[i].idx,
                          rows[i].chk, rows[i].ans);

        // Random part in windows that fill, drain or churn the table, so it
        // reaches both full and empty many times.
        ins_w = 50;
        rem_w = 20;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 160 == 0) begin
                case ($urandom_range(0, 2))
                    0: begin ins_w = 75; rem_w = 8;  end
                    1: begin ins_w = 20; rem_w = 45; end
                    default: begin ins_w = 40; rem_w = 25; end
                endcase
            end
            r = $urandom_range(0, 99);
            if (r < ins_w)
                k = bpei_pkg::KIND_INSERT;
            else if (r < ins_w + rem_w)
                k = bpei_pkg::KIND_REMOVE;
            else if (r < 98)
                k = bpei_pkg::KIND_QUERY;
            else
                k = bpei_pkg::KIND_CLEAR;
            idx = ($urandom_range(0, 9) < 8) ? 6'($urandom_range(0, env_count))
                                             : 6'($urandom);
            offer_request(k, pick_time(), pick_value(), idx, 0, none);
        end
        i_s_tvalid   <= 1'b0;
        sending_done = 1'b1;
    end

    // Receiver: random stalls, plus one long hold so the block backs up.
    initial begin
        int hold;
        bit held;
        i_m_tready = 1'b0;
        hold = 0;
        held = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!held && answers_seen >= 200) begin
                held = 1'b1;
                hold = LONG_HOLD;
            end
            if (hold > 0) begin
                hold--;
                i_m_tready <= 1'b0;
            end else if ($urandom_range(0, 9) < 7) begin
                i_m_tready <= 1'b1;
            end else begin
                i_m_tready <= 1'b0;
                hold = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3)
                                                  : $urandom_range(10, 60);
            end
        end
    end

    // Checker and watchdog.
    initial begin
        failed       = 1'b0;
        answers_seen = 0;
        idle_cycles  = 0;
    end

    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            answers_seen <= answers_seen + 1;
            if (answers_due.size() == 0) begin
                $error("result with nothing pending: %h", o_m_tdata);
                failed = 1'b1;
            end else begin
                want = answers_due.pop_front();
                if (o_m_tdata[16:0] !== want.level) begin
                    $error("level: expected %0d, got %0d", want.level, o_m_tdata[16:0]);
                    failed = 1'b1;
                end
                if (o_m_tdata[23:17] !== want.count) begin
                    $error("point_count: expected %0d, got %0d", want.count,
                           o_m_tdata[23:17]);
                    failed = 1'b1;
                end
                if (o_m_tdata[25:24] !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_m_tdata[25:24]);
                    failed = 1'b1;
                end
            end
        end
        if ((o_m_tvalid && i_m_tready) || (i_s_tvalid && o_s_tready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_breakpoint_envelope_interpolator_top: errors");
            $finish;
        end
    end

    // End of run: everything sent and answered, then a short drain.
    initial begin
        wait (sending_done);
        while (answers_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (!failed && answers_due.size() == 0)
            $display("tb_breakpoint_envelope_interpolator_top: clean");
        else
            $display("tb_breakpoint_envelope_interpolator_top: errors");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/bpei_pkg.sv
hw/rtl/bpei_cell.sv
hw/rtl/breakpoint_envelope_interpolator_top.sv
tb/tb_breakpoint_envelope_interpolator_top.sv
